FILE: rtl/core/hex_trace_line_decoder_assert.svh
// assertion helpers shared by the decoder modules
// each use expects signals named clk and rst_n in scope
`ifndef HEX_TRACE_LINE_DECODER_ASSERT_SVH
`define HEX_TRACE_LINE_DECODER_ASSERT_SVH

// condition holds at every sampled edge
`define HTLD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define HTLD_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define HTLD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/htld_pkg.sv
package htld_pkg;

    // default segment buffer size in bytes
    localparam int SEGMENT_MAX_DEF = 8192;

    // depth of the queues between front, back and result side
    localparam int QUEUE_DEPTH = 2;

    // characters of interest
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_F     = 8'h66;

    // telnet codes
    localparam logic [7:0] IAC_BYTE = 8'hff;
    localparam logic [7:0] EOR_BYTE = 8'hef;

    // classified character word, front to back
    typedef struct packed {
        logic       is_eof;
        logic       mode;
        logic       hex_ok;
        logic [3:0] hex_val;
        logic       is_nl;
        logic       is_blank;
        logic       is_lt;
        logic       is_space;
        logic       is_zero;
        logic       is_x;
    } cls_t;

    // result word, back to result queue
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] data_byte;
        logic       segment_end;
        logic       step_done;
        logic       discard;
        logic       format_error;
        logic       file_ended;
    } result_t;

endpackage

FILE: rtl/core/htld_fifo.sv
module htld_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    `include "hex_trace_line_decoder_assert.svh"

    `HTLD_ASSERT_ALWAYS(a_fifo_count_bound, count_reg <= CNT_FULL, "fifo count above depth")
    `HTLD_ASSERT_NEXT(a_fifo_drain, do_pop && !do_push && count_reg == 1, empty, "fifo not empty after last pop")
    `HTLD_ASSERT_NEXT(a_fifo_fill, do_push && !do_pop, !empty, "fifo empty after push")
endmodule

FILE: rtl/core/htld_front.sv
module htld_front #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        file_char,
    input  logic              stop_at_eor,
    input  logic              end_of_file,
    input  logic              push,
    output logic              full,
    input  logic              cls_take,
    output logic              cls_valid,
    output htld_pkg::cls_t    cls
);
    import htld_pkg::*;

    cls_t             cls_in;
    logic             is_digit;
    logic             is_letter;
    logic             cls_empty;
    logic [$bits(cls_t)-1:0] cls_rdata;

    // character classification
    always_comb
    begin
        is_digit        = (file_char >= CH_ZERO) && (file_char <= CH_NINE);
        is_letter       = (file_char >= CH_A) && (file_char <= CH_F);
        cls_in.is_eof   = end_of_file;
        cls_in.mode     = stop_at_eor;
        cls_in.hex_ok   = is_digit || is_letter;
        cls_in.hex_val  = is_letter ? (file_char[3:0] + 4'd9) : file_char[3:0];
        cls_in.is_nl    = (file_char == CH_NL);
        cls_in.is_blank = (file_char == CH_SPACE) || (file_char == CH_TAB);
        cls_in.is_lt    = (file_char == CH_LT);
        cls_in.is_space = (file_char == CH_SPACE);
        cls_in.is_zero  = (file_char == CH_ZERO);
        cls_in.is_x     = (file_char == CH_X);
    end

    // queue of classified words toward the parser
    htld_fifo #(
        .WIDTH ($bits(cls_t)),
        .DEPTH (DEPTH)
    ) u_cls_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cls_in),
        .full  (full),
        .pop   (cls_take),
        .rdata (cls_rdata),
        .empty (cls_empty)
    );

    assign cls_valid = !cls_empty;
    assign cls       = cls_t'(cls_rdata);
endmodule

FILE: rtl/core/htld_back.sv
module htld_back #(
    parameter int SEGMENT_MAX = htld_pkg::SEGMENT_MAX_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cls_valid,
    input  htld_pkg::cls_t    cls,
    output logic              cls_take,
    input  logic              res_full,
    output logic              res_push,
    output htld_pkg::result_t res
);
    import htld_pkg::*;

    localparam int CNT_W = $clog2(SEGMENT_MAX + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SEGMENT_MAX - 1);

    typedef enum logic [3:0] {
        PH_LINE = 4'd0,
        PH_SKIP = 4'd1,
        PH_LT   = 4'd2,
        PH_SP   = 4'd3,
        PH_ZERO = 4'd4,
        PH_X    = 4'd5,
        PH_OFS  = 4'd6,
        PH_GAP  = 4'd7,
        PH_HI   = 4'd8,
        PH_LO   = 4'd9
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [3:0]       high_nibble_reg, high_nibble_next;
    logic             after_iac_reg, after_iac_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             tail_iac_reg, tail_iac_next;
    logic             tail_eor_reg, tail_eor_next;
    phase_t           skip_phase;
    logic [7:0]       pair_byte;
    logic             commit;
    logic             at_eor;
    logic             consume;
    result_t          res_w;

    assign cls_take   = cls_valid && !res_full;
    assign consume    = cls_take;
    assign skip_phase = cls.is_nl ? PH_LINE : PH_SKIP;
    assign pair_byte  = {high_nibble_reg, cls.hex_val};

    // line parser and segment tracking
    always_comb
    begin
        phase_next       = phase_reg;
        high_nibble_next = high_nibble_reg;
        after_iac_next   = after_iac_reg;
        count_next       = count_reg;
        tail_iac_next    = tail_iac_reg;
        tail_eor_next    = tail_eor_reg;
        commit           = 1'b0;
        at_eor           = 1'b0;
        res_w            = '0;
        if (cls.is_eof)
        begin
            res_w.file_ended = 1'b1;
            res_w.discard    = 1'b1;
            phase_next       = PH_LINE;
            after_iac_next   = 1'b0;
            count_next       = '0;
            tail_iac_next    = 1'b0;
            tail_eor_next    = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                PH_SKIP:
                begin
                    if (cls.is_nl)
                    begin
                        phase_next = PH_LINE;
                    end
                end
                PH_LT:
                begin
                    phase_next = cls.is_space ? PH_SP : skip_phase;
                end
                PH_SP:
                begin
                    phase_next = cls.is_zero ? PH_ZERO : skip_phase;
                end
                PH_ZERO:
                begin
                    phase_next = cls.is_x ? PH_X : skip_phase;
                end
                PH_X:
                begin
                    phase_next = cls.hex_ok ? PH_OFS : skip_phase;
                end
                PH_OFS:
                begin
                    if (cls.hex_ok)
                    begin
                        phase_next = PH_OFS;
                    end
                    else if (cls.is_blank)
                    begin
                        phase_next = PH_GAP;
                    end
                    else
                    begin
                        phase_next = skip_phase;
                    end
                end
                PH_GAP:
                begin
                    if (cls.hex_ok)
                    begin
                        high_nibble_next = cls.hex_val;
                        phase_next       = PH_HI;
                        count_next       = '0;
                        tail_iac_next    = 1'b0;
                        tail_eor_next    = 1'b0;
                    end
                    else if (!cls.is_blank)
                    begin
                        phase_next = skip_phase;
                    end
                end
                PH_HI:
                begin
                    if (cls.hex_ok)
                    begin
                        res_w.byte_valid = 1'b1;
                        res_w.data_byte  = pair_byte;
                        phase_next       = PH_LO;
                        if (!after_iac_reg)
                        begin
                            after_iac_next = (pair_byte == IAC_BYTE);
                        end
                        else
                        begin
                            at_eor         = cls.mode && (pair_byte == EOR_BYTE);
                            after_iac_next = 1'b0;
                        end
                        tail_eor_next = tail_iac_reg && (pair_byte == EOR_BYTE);
                        tail_iac_next = (pair_byte == IAC_BYTE);
                        count_next    = count_reg + 1'b1;
                        commit        = at_eor || (count_reg == CNT_LAST);
                    end
                    else
                    begin
                        res_w.format_error = 1'b1;
                        res_w.discard      = 1'b1;
                        count_next         = '0;
                        tail_iac_next      = 1'b0;
                        tail_eor_next      = 1'b0;
                        phase_next         = skip_phase;
                    end
                end
                PH_LO:
                begin
                    if (cls.hex_ok)
                    begin
                        high_nibble_next = cls.hex_val;
                        phase_next       = PH_HI;
                    end
                    else if (cls.is_nl)
                    begin
                        phase_next = PH_LINE;
                        commit     = 1'b1;
                    end
                    else
                    begin
                        res_w.format_error = 1'b1;
                        res_w.discard      = 1'b1;
                        count_next         = '0;
                        tail_iac_next      = 1'b0;
                        tail_eor_next      = 1'b0;
                        phase_next         = skip_phase;
                    end
                end
                default:
                begin
                    phase_next = cls.is_lt ? PH_LT : skip_phase;
                end
            endcase
            // segment commit
            if (commit)
            begin
                res_w.segment_end = 1'b1;
                res_w.step_done   = !cls.mode || tail_eor_next;
                count_next        = '0;
                tail_iac_next     = 1'b0;
                tail_eor_next     = 1'b0;
            end
        end
    end

    assign res      = res_w;
    assign res_push = consume && (res_w.byte_valid || res_w.segment_end || res_w.step_done
                                  || res_w.discard || res_w.format_error || res_w.file_ended);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_LINE;
            high_nibble_reg <= '0;
            after_iac_reg   <= 1'b0;
            count_reg       <= '0;
            tail_iac_reg    <= 1'b0;
            tail_eor_reg    <= 1'b0;
        end
        else if (consume)
        begin
            phase_reg       <= phase_next;
            high_nibble_reg <= high_nibble_next;
            after_iac_reg   <= after_iac_next;
            count_reg       <= count_next;
            tail_iac_reg    <= tail_iac_next;
            tail_eor_reg    <= tail_eor_next;
        end
    end

    `include "hex_trace_line_decoder_assert.svh"

    `HTLD_ASSERT_ALWAYS(a_count_below_max, count_reg <= CNT_LAST, "segment count reached buffer size")
    `HTLD_ASSERT_IMPLY(a_step_needs_end, res_push && res.step_done, res.segment_end, "step done without segment end")
    `HTLD_ASSERT_IMPLY(a_error_drops, res_push && res.format_error, res.discard && !res.byte_valid, "format error without discard")
    `HTLD_ASSERT_NEXT(a_eof_clears, consume && cls.is_eof, phase_reg == PH_LINE && count_reg == '0 && !after_iac_reg, "end of text left parser state")
endmodule

FILE: rtl/core/hex_trace_line_decoder.sv
// channel  | handshake         | words
// ---------+-------------------+---------------------------------------------
// input    | push / full       | file_char, stop_at_eor, end_of_file
// result   | empty / pop       | byte_valid, data_byte, segment_end, step_done,
//          |                   | discard, format_error, file_ended
//
// one character per cycle unless stalled; the parser steps once per character
// a word reaches the result ports through the classify queue, then the result
// queue that the parser writes; characters with no result leave none
// reset is asynchronous active low; it empties both queues, parser to line start
// a full result queue stalls the parser, which then fills the input queue
module hex_trace_line_decoder #(
    parameter int SEGMENT_MAX = htld_pkg::SEGMENT_MAX_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] file_char,
    input  logic       stop_at_eor,
    input  logic       end_of_file,
    input  logic       pop,
    output logic       empty,
    output logic       byte_valid,
    output logic [7:0] data_byte,
    output logic       segment_end,
    output logic       step_done,
    output logic       discard,
    output logic       format_error,
    output logic       file_ended
);
    import htld_pkg::*;

    cls_t    cls;
    logic    cls_valid;
    logic    cls_take;
    result_t res;
    result_t res_out;
    logic    res_push;
    logic    res_full;
    logic [$bits(result_t)-1:0] res_rdata;

    // front: classify and queue characters
    htld_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .file_char   (file_char),
        .stop_at_eor (stop_at_eor),
        .end_of_file (end_of_file),
        .push        (push),
        .full        (full),
        .cls_take    (cls_take),
        .cls_valid   (cls_valid),
        .cls         (cls)
    );

    // back: line parser and segment logic
    htld_back #(
        .SEGMENT_MAX (SEGMENT_MAX)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_valid (cls_valid),
        .cls       (cls),
        .cls_take  (cls_take),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    // result queue
    htld_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign res_out      = result_t'(res_rdata);
    assign byte_valid   = res_out.byte_valid;
    assign data_byte    = res_out.data_byte;
    assign segment_end  = res_out.segment_end;
    assign step_done    = res_out.step_done;
    assign discard      = res_out.discard;
    assign format_error = res_out.format_error;
    assign file_ended   = res_out.file_ended;
endmodule

FILE: tb/sv/htld_tb_pkg.sv
package htld_tb_pkg;

    import htld_pkg::*;

    // where the decoder stands within a trace line
    typedef enum logic [3:0] {
        AT_LINE_START,
        SKIPPING,
        SAW_LT,
        SAW_SPACE,
        SAW_ZERO,
        SAW_X,
        IN_OFFSET,
        IN_GAP,
        HALF_BYTE,
        FULL_BYTE
    } line_phase_t;

    class trace_decode_checker;

        int          seg_limit;
        line_phase_t phase;
        logic [3:0]  hi_nibble;
        bit          iac_armed;
        int          seg_bytes;
        bit          ends_iac;
        bit          ends_iac_eor;
        result_t     expected_words[$];
        int          errors;

        function new(int limit);
            seg_limit = limit;
            phase = AT_LINE_START;
            hi_nibble = '0;
            iac_armed = 1'b0;
            errors = 0;
            drop_segment();
        endfunction

        function void drop_segment();
            seg_bytes = 0;
            ends_iac = 1'b0;
            ends_iac_eor = 1'b0;
        endfunction

        // a newline restarts the line at once, anything else skips to it
        function void skip_to_newline(logic [7:0] ch);
            phase = (ch == CH_NL) ? AT_LINE_START : SKIPPING;
        endfunction

        // lowercase hex digit value, -1 for anything else
        function int hex_digit(logic [7:0] ch);
            if (ch >= CH_ZERO && ch <= CH_NINE)
                return int'(ch - CH_ZERO);
            if (ch >= CH_A && ch <= CH_F)
                return int'(ch - CH_A) + 10;
            return -1;
        endfunction

        function string show(result_t w);
            return $sformatf("bv=%0b byte=%02h se=%0b sd=%0b dc=%0b fe=%0b fend=%0b",
                             w.byte_valid, w.data_byte, w.segment_end, w.step_done,
                             w.discard, w.format_error, w.file_ended);
        endfunction

        // advance the line parser by one accepted character word
        function void note_char(logic [7:0] ch, logic rec_mode, logic eof);
            result_t    w;
            int         h;
            bit         commit;
            bit         at_eor;
            bit         blank;
            logic [7:0] data;
            w = '0;
            h = hex_digit(ch);
            commit = 1'b0;
            at_eor = 1'b0;
            blank = (ch == CH_SPACE || ch == CH_TAB);
            if (eof)
            begin
                w.file_ended = 1'b1;
                w.discard = 1'b1;
                phase = AT_LINE_START;
                iac_armed = 1'b0;
                drop_segment();
            end
            else
            begin
                case (phase)
                    SKIPPING:
                    begin
                        if (ch == CH_NL)
                            phase = AT_LINE_START;
                    end
                    SAW_LT:
                    begin
                        if (ch == CH_SPACE) phase = SAW_SPACE;
                        else skip_to_newline(ch);
                    end
                    SAW_SPACE:
                    begin
                        if (ch == CH_ZERO) phase = SAW_ZERO;
                        else skip_to_newline(ch);
                    end
                    SAW_ZERO:
                    begin
                        if (ch == CH_X) phase = SAW_X;
                        else skip_to_newline(ch);
                    end
                    SAW_X:
                    begin
                        if (h >= 0) phase = IN_OFFSET;
                        else skip_to_newline(ch);
                    end
                    IN_OFFSET:
                    begin
                        if (h >= 0) phase = IN_OFFSET;
                        else if (blank) phase = IN_GAP;
                        else skip_to_newline(ch);
                    end
                    // first data digit opens a fresh segment
                    IN_GAP:
                    begin
                        if (h >= 0)
                        begin
                            hi_nibble = h[3:0];
                            phase = HALF_BYTE;
                            drop_segment();
                        end
                        else if (!blank)
                        begin
                            skip_to_newline(ch);
                        end
                    end
                    // low digit completes a byte, with telnet tracking
                    HALF_BYTE:
                    begin
                        if (h >= 0)
                        begin
                            data = {hi_nibble, h[3:0]};
                            w.byte_valid = 1'b1;
                            w.data_byte = data;
                            phase = FULL_BYTE;
                            if (!iac_armed)
                            begin
                                iac_armed = (data == IAC_BYTE);
                            end
                            else
                            begin
                                at_eor = rec_mode && data == EOR_BYTE;
                                iac_armed = 1'b0;
                            end
                            ends_iac_eor = ends_iac && data == EOR_BYTE;
                            ends_iac = (data == IAC_BYTE);
                            seg_bytes++;
                            if (at_eor || seg_bytes >= seg_limit)
                                commit = 1'b1;
                        end
                        else
                        begin
                            w.format_error = 1'b1;
                            w.discard = 1'b1;
                            drop_segment();
                            skip_to_newline(ch);
                        end
                    end
                    FULL_BYTE:
                    begin
                        if (h >= 0)
                        begin
                            hi_nibble = h[3:0];
                            phase = HALF_BYTE;
                        end
                        else if (ch == CH_NL)
                        begin
                            phase = AT_LINE_START;
                            commit = 1'b1;
                        end
                        else
                        begin
                            w.format_error = 1'b1;
                            w.discard = 1'b1;
                            drop_segment();
                            skip_to_newline(ch);
                        end
                    end
                    default:
                    begin
                        if (ch == CH_LT) phase = SAW_LT;
                        else skip_to_newline(ch);
                    end
                endcase
                if (commit)
                begin
                    w.segment_end = 1'b1;
                    w.step_done = !rec_mode || ends_iac_eor;
                    drop_segment();
                end
            end
            if (w != '0)
                expected_words.push_back(w);
        endfunction

        // compare one popped word with the oldest expectation
        function void check_word(result_t got);
            result_t want;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual %s", $time, show(got));
                errors++;
                return;
            end
            want = expected_words.pop_front();
            if (got !== want)
            begin
                $display("%0t: word mismatch, expected %s, actual %s",
                         $time, show(want), show(got));
                errors++;
            end
        endfunction

        function int waiting();
            return expected_words.size();
        endfunction

    endclass

endpackage

FILE: tb/sv/tb.sv
module tb;

    import htld_pkg::*;
    import htld_tb_pkg::*;

    // small segment buffer so that the full-buffer commit shows up often
    localparam int SEG_MAX      = 16;
    localparam int RANDOM_ITEMS = 420;
    localparam int HOLD_AT      = 30;
    localparam int HOLD_CYCLES  = 100;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct packed {
        logic [7:0] ch;
        logic       rec;
        logic       eof;
    } text_char_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] file_char = '0;
    logic       stop_at_eor = 1'b0;
    logic       end_of_file = 1'b0;
    logic       pop = 1'b0;
    logic       empty;
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       segment_end;
    logic       step_done;
    logic       discard;
    logic       format_error;
    logic       file_ended;

    trace_decode_checker decoder_sb;
    text_char_t          text_q[$];
    bit                  send_burst = 1'b0;
    bit                  take_burst = 1'b0;
    int                  words_taken = 0;

    hex_trace_line_decoder #(
        .SEGMENT_MAX(SEG_MAX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .file_char(file_char),
        .stop_at_eor(stop_at_eor),
        .end_of_file(end_of_file),
        .pop(pop),
        .empty(empty),
        .byte_valid(byte_valid),
        .data_byte(data_byte),
        .segment_end(segment_end),
        .step_done(step_done),
        .discard(discard),
        .format_error(format_error),
        .file_ended(file_ended)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] hex_char(int v);
        return (v < 10) ? CH_ZERO + 8'(v) : CH_A + 8'(v - 10);
    endfunction

    function automatic void put_char(logic [7:0] ch, logic rec, logic eof);
        text_char_t w;
        w.ch = ch;
        w.rec = rec;
        w.eof = eof;
        text_q.push_back(w);
    endfunction

    function automatic void put_text(string s, logic rec);
        for (int i = 0; i < s.len(); i++)
            put_char(s[i], rec, 1'b0);
    endfunction

    // offer one character word after a random gap, return once taken
    task automatic push_char(text_char_t w);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        file_char <= w.ch;
        stop_at_eor <= w.rec;
        end_of_file <= w.eof;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    // take one result word; one long hold-off lets the block back up
    task automatic pop_word();
        int gap;
        if ($urandom_range(0, 39) == 0)
            take_burst = !take_burst;
        gap = take_burst ? 0 : $urandom_range(0, 4);
        if (words_taken == HOLD_AT)
            gap = HOLD_CYCLES;
        if (gap > 0)
        begin
            pop <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pop <= 1'b1;
        @(posedge clk);
        while (empty) @(posedge clk);
        words_taken++;
    endtask

    // monitor both handshakes at each edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                decoder_sb.note_char(file_char, stop_at_eor, end_of_file);
            if (pop && !empty)
                decoder_sb.check_word(result_t'({byte_valid, data_byte, segment_end,
                                                  step_done, discard, format_error,
                                                  file_ended}));
        end
    end

    // result side
    initial
    begin
        wait (rst_n === 1'b1);
        forever pop_word();
    end

    // stall watchdog
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("[hex_trace_line_decoder] ERROR");
        $finish;
    end

    initial
    begin : run
        logic [7:0] line_chars[$];
        logic [7:0] b;
        int         directed_len;
        int         kind;
        int         n;
        int         pick;
        bit         rec;
        decoder_sb = new(SEG_MAX);

        // record mode: IAC EOR commits with step done, then an empty commit
        put_text("< 0xa ffef\n", 1'b1);
        // prefix broken by a top-bit char, then by the newline itself
        put_char(CH_LT, 1'b0, 1'b0);
        put_char(8'hff, 1'b0, 1'b0);
        put_char(CH_NL, 1'b0, 1'b0);
        put_text("<\n", 1'b0);
        // NUL where the low digit belongs
        put_text("< 0x1\t0", 1'b0);
        put_char(8'h00, 1'b0, 1'b0);
        put_char(CH_NL, 1'b0, 1'b0);
        // end of text
        put_char(8'hff, 1'b1, 1'b1);
        directed_len = text_q.size();

        // random lines: mostly well formed, some broken, some noise, some end-of-text marks
        while (text_q.size() < directed_len + RANDOM_ITEMS)
        begin
            rec = 1'($urandom_range(0, 1));
            kind = $urandom_range(0, 9);
            line_chars.delete();
            if (kind == 1)
            begin
                put_char(8'($urandom_range(0, 255)), rec, 1'b1);
                continue;
            end
            if (kind == 0)
            begin
                n = $urandom_range(1, 12);
                repeat (n) line_chars.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                line_chars = '{CH_LT, CH_SPACE, CH_ZERO, CH_X};
                n = $urandom_range(1, 4);
                repeat (n) line_chars.push_back(hex_char($urandom_range(0, 15)));
                n = $urandom_range(1, 3);
                repeat (n) line_chars.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
                if ($urandom_range(0, 5) == 0)
                    n = $urandom_range(SEG_MAX - 2, 2 * SEG_MAX + 1);
                else
                    n = $urandom_range(0, 10);
                // bytes lean toward telnet IAC and EOR
                repeat (n)
                begin
                    pick = $urandom_range(0, 7);
                    if (pick == 0)
                    begin
                        line_chars.push_back(hex_char(IAC_BYTE[7:4]));
                        line_chars.push_back(hex_char(IAC_BYTE[3:0]));
                        b = EOR_BYTE;
                    end
                    else if (pick == 1)
                        b = IAC_BYTE;
                    else if (pick == 2)
                        b = EOR_BYTE;
                    else
                        b = 8'($urandom_range(0, 255));
                    line_chars.push_back(hex_char(b[7:4]));
                    line_chars.push_back(hex_char(b[3:0]));
                end
                // break a line now and then: stray char or odd digit count
                pick = $urandom_range(0, 7);
                if (pick == 0)
                    line_chars[$urandom_range(0, line_chars.size() - 1)] =
                        8'($urandom_range(0, 255));
                else if (pick == 1)
                    line_chars.push_back(hex_char($urandom_range(0, 15)));
            end
            foreach (line_chars[i])
                put_char(line_chars[i], ($urandom_range(0, 19) == 0) ? !rec : rec, 1'b0);
            if ($urandom_range(0, 15) != 0)
                put_char(CH_NL, rec, 1'b0);
        end

        // reset, then stream the text
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        foreach (text_q[i])
            push_char(text_q[i]);
        push <= 1'b0;

        // drain outstanding words, then watch for strays
        while (decoder_sb.waiting() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (decoder_sb.errors == 0 && decoder_sb.waiting() == 0)
            $display("[hex_trace_line_decoder] OK");
        else
            $display("[hex_trace_line_decoder] ERROR");
        $finish;
    end

endmodule
